>>> rtl/core/tvr_pkg.sv
// Package for the tow point velocity rotation block.
// Holds the fixed-point constants, CORDIC arctangent table and rounding helpers.
// Depends on nothing.
package tvr_pkg;

    localparam int STEPS = 30;
    localparam int NSTAGE = 41;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic signed [31:0] LEVER_X_RST = -32'sd14418;
    localparam logic signed [31:0] LEVER_Y_RST = 32'sd0;
    localparam logic signed [31:0] LEVER_Z_RST = -32'sd326;

    typedef enum logic [1:0] {
        CFG_LEVER_X = 2'd0,
        CFG_LEVER_Y = 2'd1,
        CFG_LEVER_Z = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               flip;
    } cord_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] r;
        case (i)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd7;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [33:0] rnd30(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = (p + 68'sd536870912) >>> 30;
        return t[33:0];
    endfunction

    function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = (p + 64'sd32768) >>> 16;
        return t[47:0];
    endfunction

endpackage

>>> rtl/core/towpoint_velocity_rotation.sv
// Tow point velocity rotation: v + w x r, rotated by Rx*Ry*Rz, saturated to Q16.16.
// One beat per cycle is accepted while the output beat is not held by out_stall.
// Each angle goes through a fully pipelined 30 step CORDIC, followed by the product stages.
// The whole pipeline advances unless the output beat is held by out_stall.
// Reset clears all valid bits and loads the lever arm registers with their defaults.
// Depends on tvr_pkg.
module towpoint_velocity_rotation (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] rel_vel_x,
    input  logic signed [31:0] rel_vel_y,
    input  logic signed [31:0] rel_vel_z,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    input  logic signed [15:0] angle_x,
    input  logic signed [15:0] angle_y,
    input  logic signed [15:0] angle_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata
);

    logic en;
    logic vld_reg [0:tvr_pkg::NSTAGE-1];

    logic signed [31:0] lever_x_reg, lever_y_reg, lever_z_reg;

    logic signed [31:0] vin_reg [0:2];
    logic signed [31:0] win_reg [0:2];
    logic signed [15:0] ang_reg [0:2];

    logic signed [31:0] vb_reg [0:2];
    logic signed [63:0] xp_reg [0:5];
    tvr_pkg::cord_t     cord_reg [0:tvr_pkg::STEPS][0:2];
    logic signed [49:0] bp_reg [2:36][0:2];

    logic signed [33:0] s_reg [0:2];
    logic signed [33:0] c_reg [0:2];
    logic signed [67:0] p1_reg [0:9];
    logic signed [33:0] p1_sb_reg, p1_sc_reg, p1_cc_reg;
    logic signed [33:0] q_reg [0:9];
    logic signed [33:0] q_sb_reg, q_sc_reg, q_cc_reg;
    logic signed [67:0] m_reg [0:3];
    logic signed [33:0] r_reg [2:9];
    logic signed [33:0] r_sb_reg;
    logic signed [33:0] e_reg [0:2][0:2];
    logic signed [59:0] ph_reg [0:2][0:2];
    logic signed [58:0] pl_reg [0:2][0:2];
    logic signed [61:0] shi_reg [0:2];
    logic signed [61:0] slo_reg [0:2];
    logic signed [87:0] tot_reg [0:2];
    logic signed [31:0] res_reg [0:2];

    tvr_pkg::cord_t     cord_next [1:tvr_pkg::STEPS][0:2];
    tvr_pkg::cord_t     init_next [0:2];
    logic signed [49:0] b_next [0:2];
    logic signed [31:0] res_next [0:2];
    logic signed [15:0] ang_in [0:2];

    assign en        = !(vld_reg[tvr_pkg::NSTAGE-1] && out_stall);
    assign in_stall  = !en;
    assign out_valid = vld_reg[tvr_pkg::NSTAGE-1];
    assign out_vel_x = res_reg[0];
    assign out_vel_y = res_reg[1];
    assign out_vel_z = res_reg[2];

    assign ang_in[0] = angle_x;
    assign ang_in[1] = angle_y;
    assign ang_in[2] = angle_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lever_x_reg <= tvr_pkg::LEVER_X_RST;
            lever_y_reg <= tvr_pkg::LEVER_Y_RST;
            lever_z_reg <= tvr_pkg::LEVER_Z_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                tvr_pkg::CFG_LEVER_X: lever_x_reg <= cfg_wdata;
                tvr_pkg::CFG_LEVER_Y: lever_y_reg <= cfg_wdata;
                tvr_pkg::CFG_LEVER_Z: lever_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < tvr_pkg::NSTAGE; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < tvr_pkg::NSTAGE; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_comb
    begin
        logic signed [33:0] z0;
        for (int j = 0; j < 3; j++)
        begin
            z0 = 34'(ang_reg[j]) <<< 17;
            init_next[j].x = tvr_pkg::GAIN_Q30;
            init_next[j].y = '0;
            if (z0 > tvr_pkg::HALF_PI_Q30)
            begin
                init_next[j].z    = z0 - tvr_pkg::PI_Q30;
                init_next[j].flip = 1'b1;
            end
            else if (z0 < -tvr_pkg::HALF_PI_Q30)
            begin
                init_next[j].z    = z0 + tvr_pkg::PI_Q30;
                init_next[j].flip = 1'b1;
            end
            else
            begin
                init_next[j].z    = z0;
                init_next[j].flip = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < tvr_pkg::STEPS; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cord_next[k+1][j].flip = cord_reg[k][j].flip;
                if (cord_reg[k][j].z >= 0)
                begin
                    cord_next[k+1][j].x = cord_reg[k][j].x - (cord_reg[k][j].y >>> k);
                    cord_next[k+1][j].y = cord_reg[k][j].y + (cord_reg[k][j].x >>> k);
                    cord_next[k+1][j].z = cord_reg[k][j].z - tvr_pkg::atan_q30(k);
                end
                else
                begin
                    cord_next[k+1][j].x = cord_reg[k][j].x + (cord_reg[k][j].y >>> k);
                    cord_next[k+1][j].y = cord_reg[k][j].y - (cord_reg[k][j].x >>> k);
                    cord_next[k+1][j].z = cord_reg[k][j].z + tvr_pkg::atan_q30(k);
                end
            end
        end
    end

    always_comb
    begin
        b_next[0] = 50'(vb_reg[0]) + 50'(tvr_pkg::rnd16(xp_reg[0]))
                  - 50'(tvr_pkg::rnd16(xp_reg[1]));
        b_next[1] = 50'(vb_reg[1]) + 50'(tvr_pkg::rnd16(xp_reg[2]))
                  - 50'(tvr_pkg::rnd16(xp_reg[3]));
        b_next[2] = 50'(vb_reg[2]) + 50'(tvr_pkg::rnd16(xp_reg[4]))
                  - 50'(tvr_pkg::rnd16(xp_reg[5]));
    end

    always_comb
    begin
        logic signed [57:0] sh;
        for (int i = 0; i < 3; i++)
        begin
            sh = tot_reg[i][87:30];
            if (sh > 58'sd2147483647)
            begin
                res_next[i] = 32'sh7fffffff;
            end
            else if (sh < -58'sd2147483648)
            begin
                res_next[i] = 32'sh80000000;
            end
            else
            begin
                res_next[i] = sh[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vin_reg[0] <= rel_vel_x;
            vin_reg[1] <= rel_vel_y;
            vin_reg[2] <= rel_vel_z;
            win_reg[0] <= rate_x;
            win_reg[1] <= rate_y;
            win_reg[2] <= rate_z;
            for (int j = 0; j < 3; j++)
            begin
                ang_reg[j] <= ang_in[j];
            end

            for (int j = 0; j < 3; j++)
            begin
                vb_reg[j]      <= vin_reg[j];
                cord_reg[0][j] <= init_next[j];
            end
            xp_reg[0] <= 64'(win_reg[1]) * 64'(lever_z_reg);
            xp_reg[1] <= 64'(win_reg[2]) * 64'(lever_y_reg);
            xp_reg[2] <= 64'(win_reg[2]) * 64'(lever_x_reg);
            xp_reg[3] <= 64'(win_reg[0]) * 64'(lever_z_reg);
            xp_reg[4] <= 64'(win_reg[0]) * 64'(lever_y_reg);
            xp_reg[5] <= 64'(win_reg[1]) * 64'(lever_x_reg);

            for (int k = 1; k <= tvr_pkg::STEPS; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    cord_reg[k][j] <= cord_next[k][j];
                end
            end
            for (int j = 0; j < 3; j++)
            begin
                bp_reg[2][j] <= b_next[j];
                for (int k = 3; k <= 36; k++)
                begin
                    bp_reg[k][j] <= bp_reg[k-1][j];
                end
            end

            for (int j = 0; j < 3; j++)
            begin
                if (cord_reg[tvr_pkg::STEPS][j].flip)
                begin
                    c_reg[j] <= -cord_reg[tvr_pkg::STEPS][j].x;
                    s_reg[j] <= -cord_reg[tvr_pkg::STEPS][j].y;
                end
                else
                begin
                    c_reg[j] <= cord_reg[tvr_pkg::STEPS][j].x;
                    s_reg[j] <= cord_reg[tvr_pkg::STEPS][j].y;
                end
            end

            p1_reg[0] <= 68'(s_reg[0]) * 68'(s_reg[1]);
            p1_reg[1] <= 68'(c_reg[0]) * 68'(s_reg[1]);
            p1_reg[2] <= 68'(c_reg[1]) * 68'(c_reg[2]);
            p1_reg[3] <= 68'(c_reg[1]) * 68'(s_reg[2]);
            p1_reg[4] <= 68'(c_reg[0]) * 68'(s_reg[2]);
            p1_reg[5] <= 68'(c_reg[0]) * 68'(c_reg[2]);
            p1_reg[6] <= 68'(s_reg[0]) * 68'(s_reg[2]);
            p1_reg[7] <= 68'(s_reg[0]) * 68'(c_reg[2]);
            p1_reg[8] <= 68'(s_reg[0]) * 68'(c_reg[1]);
            p1_reg[9] <= 68'(c_reg[0]) * 68'(c_reg[1]);
            p1_sb_reg <= s_reg[1];
            p1_sc_reg <= s_reg[2];
            p1_cc_reg <= c_reg[2];

            for (int k = 0; k < 10; k++)
            begin
                q_reg[k] <= tvr_pkg::rnd30(p1_reg[k]);
            end
            q_sb_reg <= p1_sb_reg;
            q_sc_reg <= p1_sc_reg;
            q_cc_reg <= p1_cc_reg;

            m_reg[0] <= 68'(q_reg[0]) * 68'(q_cc_reg);
            m_reg[1] <= 68'(q_reg[0]) * 68'(q_sc_reg);
            m_reg[2] <= 68'(q_reg[1]) * 68'(q_cc_reg);
            m_reg[3] <= 68'(q_reg[1]) * 68'(q_sc_reg);
            for (int k = 2; k < 10; k++)
            begin
                r_reg[k] <= q_reg[k];
            end
            r_sb_reg <= q_sb_reg;

            e_reg[0][0] <= r_reg[2];
            e_reg[0][1] <= -r_reg[3];
            e_reg[0][2] <= r_sb_reg;
            e_reg[1][0] <= r_reg[4] + tvr_pkg::rnd30(m_reg[0]);
            e_reg[1][1] <= r_reg[5] - tvr_pkg::rnd30(m_reg[1]);
            e_reg[1][2] <= -r_reg[8];
            e_reg[2][0] <= r_reg[6] - tvr_pkg::rnd30(m_reg[2]);
            e_reg[2][1] <= r_reg[7] + tvr_pkg::rnd30(m_reg[3]);
            e_reg[2][2] <= r_reg[9];

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    ph_reg[i][j] <= 60'(e_reg[i][j]) * 60'($signed(bp_reg[36][j][49:24]));
                    pl_reg[i][j] <= 59'(e_reg[i][j])
                                  * 59'($signed({1'b0, bp_reg[36][j][23:0]}));
                end
            end

            for (int i = 0; i < 3; i++)
            begin
                shi_reg[i] <= 62'(ph_reg[i][0]) + 62'(ph_reg[i][1]) + 62'(ph_reg[i][2]);
                slo_reg[i] <= 62'(pl_reg[i][0]) + 62'(pl_reg[i][1]) + 62'(pl_reg[i][2]);
            end

            for (int i = 0; i < 3; i++)
            begin
                tot_reg[i] <= (88'(shi_reg[i]) <<< 24) + 88'(slo_reg[i])
                            + 88'sd536870912;
            end

            for (int i = 0; i < 3; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

endmodule

>>> rtl/core/tvr_checker.sv
// Port-level assertions for the tow point velocity rotation block.
// Bound to towpoint_velocity_rotation; uses only its ports.
module tvr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_vel_x,
    input logic signed [31:0] out_vel_y,
    input logic signed [31:0] out_vel_z
);

    // The input side is held back only by an output beat that waits.
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow the held output beat");

    // A held output beat keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_vel_x)
            && $stable(out_vel_y) && $stable(out_vel_z))
        else $error("held output beat changed");

    // A new output beat appears only after the pipeline has moved.
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_stall))
        else $error("output beat appeared while the pipeline was frozen");

    // With no input beat and no pending output beat the input side is never held.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid && !out_valid |-> !in_stall)
        else $error("stall raised with no pending output");

endmodule

bind towpoint_velocity_rotation tvr_checker u_tvr_checker (.*);
